// ===== src/iutc_pkg.sv =====
// ----------------------------------------------------------------------------
// iutc_pkg: shared types and constants of the timestamp to epoch unit
// Widths, character codes, field positions and calendar constants that the
// controller, the datapath and the top level use.
// ----------------------------------------------------------------------------
package iutc_pkg;

    // Port and field widths
    localparam int CHAR_W  = 8;
    localparam int EPOCH_W = 48;
    localparam int YEAR_W  = 14;
    localparam int FLD_W   = 7;
    localparam int MILLI_W = 10;
    localparam int IDX_W   = 5;
    localparam int CNT_W   = 2;

    // Internal arithmetic widths
    localparam int DOFF_W  = 9;
    localparam int CYC_W   = 6;
    localparam int YIN_W   = 9;
    localparam int CENT_W  = 3;
    localparam int PART_W  = 18;
    localparam int ERA_W   = 23;
    localparam int DAYS_W  = 22;
    localparam int TOD_W   = 17;
    localparam int SECS_W  = 38;

    // Number of cycles the epoch arithmetic needs after the final character
    localparam int CALC_STEPS = 6;
    localparam int STEP_W     = $clog2(CALC_STEPS);

    // Character positions in the text
    localparam logic [IDX_W-1:0] POS_YEAR_END = 5'd4;
    localparam logic [IDX_W-1:0] POS_DASH1    = 5'd4;
    localparam logic [IDX_W-1:0] POS_MONTH_END = 5'd7;
    localparam logic [IDX_W-1:0] POS_DASH2    = 5'd7;
    localparam logic [IDX_W-1:0] POS_DAY_END  = 5'd10;
    localparam logic [IDX_W-1:0] POS_TSEP     = 5'd10;
    localparam logic [IDX_W-1:0] POS_HOUR_END = 5'd13;
    localparam logic [IDX_W-1:0] POS_COLON1   = 5'd13;
    localparam logic [IDX_W-1:0] POS_MIN_END  = 5'd16;
    localparam logic [IDX_W-1:0] POS_COLON2   = 5'd16;
    localparam logic [IDX_W-1:0] POS_TAIL     = 5'd19;
    localparam logic [IDX_W-1:0] POS_SAT      = 5'd20;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_T     = 8'h54;
    localparam logic [CHAR_W-1:0] CH_Z     = 8'h5A;

    // Range limits
    localparam logic [YEAR_W-1:0] YEAR_MIN   = 14'd1970;
    localparam logic [FLD_W-1:0]  MONTH_MAX  = 7'd12;
    localparam logic [FLD_W-1:0]  DAY_MAX    = 7'd31;
    localparam logic [FLD_W-1:0]  HOUR_MAX   = 7'd23;
    localparam logic [FLD_W-1:0]  MINUTE_MAX = 7'd59;
    localparam logic [FLD_W-1:0]  SECOND_MAX = 7'd60;
    localparam logic [CNT_W-1:0]  FRAC_DIGITS = 2'd3;

    // Calendar constants; division by 400 and 100 by reciprocal multiply
    localparam logic [12:0] DIV400_MUL   = 13'd5243;
    localparam int          DIV400_SH    = 21;
    localparam logic [8:0]  YEARS_PER_ERA = 9'd400;
    localparam logic [5:0]  DIV100_MUL   = 6'd41;
    localparam int          DIV100_SH    = 12;
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
    localparam logic [17:0] DAYS_PER_ERA = 18'd146097;
    localparam logic [19:0] EPOCH_SHIFT  = 20'd719468;
    localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
    localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SEC_PER_MIN  = 6'd60;
    localparam logic [9:0]  MS_PER_SEC   = 10'd1000;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take;       // a character transaction is accepted
        logic take_last;  // the accepted character ends the text
        logic load_out;   // load the result into the output register
    } iutc_cmd_t;

    // Days from March 1 to the first day of the month, year starting in March.
    function automatic logic [DOFF_W-1:0] month_offset(input logic [FLD_W-1:0] mo);
        logic [DOFF_W-1:0] off;
        unique case (mo)
            7'd3:    off = 9'd0;
            7'd4:    off = 9'd31;
            7'd5:    off = 9'd61;
            7'd6:    off = 9'd92;
            7'd7:    off = 9'd122;
            7'd8:    off = 9'd153;
            7'd9:    off = 9'd184;
            7'd10:   off = 9'd214;
            7'd11:   off = 9'd245;
            7'd12:   off = 9'd275;
            7'd1:    off = 9'd306;
            7'd2:    off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

// ===== src/iutc_ctrl.sv =====
// ----------------------------------------------------------------------------
// iutc_ctrl: controller of the timestamp to epoch unit
// Accepts characters while parsing, runs the fixed-length epoch calculation
// after the final character and hands the result to the output register.
// ----------------------------------------------------------------------------
module iutc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tlast,
    output logic               s_tready,
    input  logic               m_tready,
    output logic               m_tvalid,
    output iutc_pkg::iutc_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_RUN,
        S_CALC,
        S_DONE
    } state_t;

    state_t                        state_reg;
    logic [iutc_pkg::STEP_W-1:0]   step_reg;
    logic                          ready_reg;
    logic                          mvalid_reg;
    logic                          take;
    logic                          out_free;
    logic                          load_out;

    assign take     = s_tvalid && ready_reg;
    assign out_free = !mvalid_reg || m_tready;
    assign load_out = (state_reg == S_DONE) && out_free;

    // Commands to the datapath
    always_comb begin
        cmd.take      = take;
        cmd.take_last = take && s_tlast;
        cmd.load_out  = load_out;
    end

    assign s_tready = ready_reg;
    assign m_tvalid = mvalid_reg;

    // State, step counter and handshake flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_RUN;
            step_reg   <= '0;
            ready_reg  <= 1'b1;
            mvalid_reg <= 1'b0;
        end else begin
            // A taken result clears the flag unless a new one is loaded now.
            if (mvalid_reg && m_tready && !load_out) begin
                mvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_RUN: begin
                    if (take && s_tlast) begin
                        state_reg <= S_CALC;
                        step_reg  <= '0;
                        ready_reg <= 1'b0;
                    end
                end
                S_CALC: begin
                    step_reg <= step_reg + iutc_pkg::STEP_W'(1);
                    if (step_reg == iutc_pkg::STEP_W'(iutc_pkg::CALC_STEPS - 1)) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        mvalid_reg <= 1'b1;
                        ready_reg  <= 1'b1;
                        state_reg  <= S_RUN;
                    end
                end
                default: begin
                    state_reg <= S_RUN;
                end
            endcase
        end
    end

endmodule

// ===== src/iutc_dp.sv =====
// ----------------------------------------------------------------------------
// iutc_dp: datapath of the timestamp to epoch unit
// Character parser with digit accumulators, a snapshot of the fields at the
// final character, the staged days-from-civil arithmetic and the output
// register.
// ----------------------------------------------------------------------------
module iutc_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  iutc_pkg::iutc_cmd_t               cmd,
    input  logic [iutc_pkg::CHAR_W-1:0]       s_char,
    output logic                              valid_res,
    output logic [iutc_pkg::EPOCH_W-1:0]      epoch_ms
);

    // Accumulate one decimal digit, truncated to the field width.
    function automatic logic [iutc_pkg::YEAR_W-1:0] push_year(
        input logic [iutc_pkg::YEAR_W-1:0] acc, input logic [3:0] d);
        logic [iutc_pkg::YEAR_W+3:0] s;
        s = (iutc_pkg::YEAR_W+4)'({acc, 3'b000}) + (iutc_pkg::YEAR_W+4)'({acc, 1'b0})
            + (iutc_pkg::YEAR_W+4)'(d);
        return s[iutc_pkg::YEAR_W-1:0];
    endfunction

    function automatic logic [iutc_pkg::FLD_W-1:0] push_fld(
        input logic [iutc_pkg::FLD_W-1:0] acc, input logic [3:0] d);
        logic [iutc_pkg::FLD_W+3:0] s;
        s = (iutc_pkg::FLD_W+4)'({acc, 3'b000}) + (iutc_pkg::FLD_W+4)'({acc, 1'b0})
            + (iutc_pkg::FLD_W+4)'(d);
        return s[iutc_pkg::FLD_W-1:0];
    endfunction

    function automatic logic [iutc_pkg::MILLI_W-1:0] push_milli(
        input logic [iutc_pkg::MILLI_W-1:0] acc, input logic [3:0] d);
        logic [iutc_pkg::MILLI_W+3:0] s;
        s = (iutc_pkg::MILLI_W+4)'({acc, 3'b000}) + (iutc_pkg::MILLI_W+4)'({acc, 1'b0})
            + (iutc_pkg::MILLI_W+4)'(d);
        return s[iutc_pkg::MILLI_W-1:0];
    endfunction

    // Parser state
    logic [iutc_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic                         frac_mode_reg, frac_mode_next;
    logic                         seen_z_reg, seen_z_next;
    logic [iutc_pkg::YEAR_W-1:0]  year_reg, year_next;
    logic [iutc_pkg::FLD_W-1:0]   month_reg, month_next;
    logic [iutc_pkg::FLD_W-1:0]   day_reg, day_next;
    logic [iutc_pkg::FLD_W-1:0]   hour_reg, hour_next;
    logic [iutc_pkg::FLD_W-1:0]   minute_reg, minute_next;
    logic [iutc_pkg::FLD_W-1:0]   second_reg, second_next;
    logic [iutc_pkg::MILLI_W-1:0] milli_reg, milli_next;
    logic [iutc_pkg::CNT_W-1:0]   fcnt_reg, fcnt_next;
    logic                         ferr_reg, ferr_next;

    // Snapshot of the fields at the final character
    logic                         snap_seen_reg;
    logic                         snap_err_reg;
    logic [iutc_pkg::YEAR_W-1:0]  snap_year_reg;
    logic [iutc_pkg::FLD_W-1:0]   snap_month_reg;
    logic [iutc_pkg::FLD_W-1:0]   snap_day_reg;
    logic [iutc_pkg::FLD_W-1:0]   snap_hour_reg;
    logic [iutc_pkg::FLD_W-1:0]   snap_minute_reg;
    logic [iutc_pkg::FLD_W-1:0]   snap_second_reg;
    logic [iutc_pkg::MILLI_W-1:0] snap_milli_reg;
    logic [iutc_pkg::CNT_W-1:0]   snap_fcnt_reg;

    // Arithmetic stages
    logic                         ok_reg;
    logic [iutc_pkg::YEAR_W-1:0]  y_reg;
    logic [iutc_pkg::DOFF_W-1:0]  doff_reg;
    logic [iutc_pkg::MILLI_W-1:0] frac_reg;
    logic [iutc_pkg::TOD_W-1:0]   tod_reg;
    logic [iutc_pkg::CYC_W-1:0]   cyc_reg;
    logic [iutc_pkg::YIN_W-1:0]   yin_reg;
    logic [iutc_pkg::CENT_W-1:0]  cent_reg;
    logic [iutc_pkg::PART_W-1:0]  part_reg;
    logic [iutc_pkg::ERA_W-1:0]   era_reg;
    logic [iutc_pkg::DAYS_W-1:0]  days_reg;
    logic [iutc_pkg::SECS_W-1:0]  secs_reg;

    // Output register
    logic                         valid_out_reg;
    logic [iutc_pkg::EPOCH_W-1:0] epoch_out_reg;

    logic                         is_dig;
    logic [3:0]                   dig;
    logic                         ok_c;
    logic [iutc_pkg::MILLI_W-1:0] frac_c;
    logic [iutc_pkg::YEAR_W+12:0] div400_prod;
    logic [iutc_pkg::YEAR_W-1:0]  yin_full;
    logic [14:0]                  div100_prod;
    logic [iutc_pkg::DAYS_W+1:0]  days_full;
    logic [iutc_pkg::EPOCH_W-1:0] ms_c;

    // Next parser state for one character
    always_comb begin
        is_dig = (s_char >= iutc_pkg::CH_ZERO) && (s_char <= iutc_pkg::CH_NINE);
        dig    = is_dig ? 4'(s_char - iutc_pkg::CH_ZERO) : 4'd0;

        frac_mode_next = frac_mode_reg;
        seen_z_next    = seen_z_reg;
        year_next      = year_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        hour_next      = hour_reg;
        minute_next    = minute_reg;
        second_next    = second_reg;
        milli_next     = milli_reg;
        fcnt_next      = fcnt_reg;
        ferr_next      = ferr_reg;

        if (seen_z_reg) begin
            ferr_next = 1'b1;
        end else if (idx_reg < iutc_pkg::POS_TAIL) begin
            priority if (idx_reg == iutc_pkg::POS_DASH1 || idx_reg == iutc_pkg::POS_DASH2) begin
                if (s_char != iutc_pkg::CH_DASH) ferr_next = 1'b1;
            end else if (idx_reg == iutc_pkg::POS_TSEP) begin
                if (s_char != iutc_pkg::CH_T) ferr_next = 1'b1;
            end else if (idx_reg == iutc_pkg::POS_COLON1
                         || idx_reg == iutc_pkg::POS_COLON2) begin
                if (s_char != iutc_pkg::CH_COLON) ferr_next = 1'b1;
            end else if (!is_dig) begin
                ferr_next = 1'b1;
            end else if (idx_reg < iutc_pkg::POS_YEAR_END) begin
                year_next = push_year(year_reg, dig);
            end else if (idx_reg < iutc_pkg::POS_MONTH_END) begin
                month_next = push_fld(month_reg, dig);
            end else if (idx_reg < iutc_pkg::POS_DAY_END) begin
                day_next = push_fld(day_reg, dig);
            end else if (idx_reg < iutc_pkg::POS_HOUR_END) begin
                hour_next = push_fld(hour_reg, dig);
            end else if (idx_reg < iutc_pkg::POS_MIN_END) begin
                minute_next = push_fld(minute_reg, dig);
            end else begin
                second_next = push_fld(second_reg, dig);
            end
        end else if (idx_reg == iutc_pkg::POS_TAIL) begin
            priority if (s_char == iutc_pkg::CH_DOT) begin
                frac_mode_next = 1'b1;
            end else if (s_char == iutc_pkg::CH_Z) begin
                seen_z_next = 1'b1;
            end else begin
                ferr_next = 1'b1;
            end
        end else if (!frac_mode_reg) begin
            ferr_next = 1'b1;
        end else if (is_dig) begin
            // Digits past the third are accepted and dropped.
            if (fcnt_reg < iutc_pkg::FRAC_DIGITS) begin
                milli_next = push_milli(milli_reg, dig);
                fcnt_next  = fcnt_reg + iutc_pkg::CNT_W'(1);
            end
        end else if (s_char == iutc_pkg::CH_Z) begin
            if (fcnt_reg == '0) ferr_next = 1'b1;
            seen_z_next = 1'b1;
        end else begin
            ferr_next = 1'b1;
        end

        idx_next = (idx_reg < iutc_pkg::POS_SAT) ? idx_reg + iutc_pkg::IDX_W'(1) : idx_reg;
    end

    // Parser registers; all return to their reset values after the final character.
    always_ff @(posedge aclk) begin
        if (!aresetn || (cmd.take && cmd.take_last)) begin
            idx_reg       <= '0;
            frac_mode_reg <= 1'b0;
            seen_z_reg    <= 1'b0;
            year_reg      <= '0;
            month_reg     <= '0;
            day_reg       <= '0;
            hour_reg      <= '0;
            minute_reg    <= '0;
            second_reg    <= '0;
            milli_reg     <= '0;
            fcnt_reg      <= '0;
            ferr_reg      <= 1'b0;
        end else if (cmd.take) begin
            idx_reg       <= idx_next;
            frac_mode_reg <= frac_mode_next;
            seen_z_reg    <= seen_z_next;
            year_reg      <= year_next;
            month_reg     <= month_next;
            day_reg       <= day_next;
            hour_reg      <= hour_next;
            minute_reg    <= minute_next;
            second_reg    <= second_next;
            milli_reg     <= milli_next;
            fcnt_reg      <= fcnt_next;
            ferr_reg      <= ferr_next;
        end
    end

    // Field snapshot taken with the final character
    always_ff @(posedge aclk) begin
        if (cmd.take_last) begin
            snap_seen_reg   <= seen_z_next;
            snap_err_reg    <= ferr_next;
            snap_year_reg   <= year_next;
            snap_month_reg  <= month_next;
            snap_day_reg    <= day_next;
            snap_hour_reg   <= hour_next;
            snap_minute_reg <= minute_next;
            snap_second_reg <= second_next;
            snap_milli_reg  <= milli_next;
            snap_fcnt_reg   <= fcnt_next;
        end
    end

    // Range check and fraction padding
    always_comb begin
        ok_c = !snap_err_reg && snap_seen_reg
               && (snap_year_reg >= iutc_pkg::YEAR_MIN)
               && (snap_month_reg != '0) && (snap_month_reg <= iutc_pkg::MONTH_MAX)
               && (snap_day_reg != '0) && (snap_day_reg <= iutc_pkg::DAY_MAX)
               && (snap_hour_reg <= iutc_pkg::HOUR_MAX)
               && (snap_minute_reg <= iutc_pkg::MINUTE_MAX)
               && (snap_second_reg <= iutc_pkg::SECOND_MAX);
        unique case (snap_fcnt_reg)
            2'd0:    frac_c = '0;
            2'd1:    frac_c = iutc_pkg::MILLI_W'(snap_milli_reg * 10'd100);
            2'd2:    frac_c = iutc_pkg::MILLI_W'(snap_milli_reg * 10'd10);
            default: frac_c = snap_milli_reg;
        endcase
    end

    // Stage 1: shifted year, day of the shifted year, time of day
    always_ff @(posedge aclk) begin
        ok_reg   <= ok_c;
        frac_reg <= frac_c;
        y_reg    <= snap_year_reg
                    - iutc_pkg::YEAR_W'(snap_month_reg <= 7'd2);
        doff_reg <= iutc_pkg::month_offset(snap_month_reg)
                    + iutc_pkg::DOFF_W'(snap_day_reg) - iutc_pkg::DOFF_W'(1);
        tod_reg  <= iutc_pkg::TOD_W'(snap_hour_reg) * iutc_pkg::TOD_W'(iutc_pkg::SEC_PER_HOUR)
                    + iutc_pkg::TOD_W'(snap_minute_reg) * iutc_pkg::TOD_W'(iutc_pkg::SEC_PER_MIN)
                    + iutc_pkg::TOD_W'(snap_second_reg);
    end

    // Stage 2: era number, year divided by 400
    assign div400_prod = (iutc_pkg::YEAR_W+13)'(y_reg)
                         * (iutc_pkg::YEAR_W+13)'(iutc_pkg::DIV400_MUL);
    always_ff @(posedge aclk) begin
        cyc_reg <= iutc_pkg::CYC_W'(div400_prod >> iutc_pkg::DIV400_SH);
    end

    // Stage 3: year of era
    assign yin_full = y_reg - iutc_pkg::YEAR_W'(cyc_reg) * iutc_pkg::YEAR_W'(iutc_pkg::YEARS_PER_ERA);
    always_ff @(posedge aclk) begin
        yin_reg <= yin_full[iutc_pkg::YIN_W-1:0];
    end

    // Stage 4: century count, day of era without centuries, days of whole eras
    assign div100_prod = 15'(yin_reg) * 15'(iutc_pkg::DIV100_MUL);
    always_ff @(posedge aclk) begin
        cent_reg <= iutc_pkg::CENT_W'(div100_prod >> iutc_pkg::DIV100_SH);
        part_reg <= iutc_pkg::PART_W'(yin_reg) * iutc_pkg::PART_W'(iutc_pkg::DAYS_PER_YEAR)
                    + iutc_pkg::PART_W'(yin_reg >> 2)
                    + iutc_pkg::PART_W'(doff_reg);
        era_reg  <= iutc_pkg::ERA_W'(cyc_reg) * iutc_pkg::ERA_W'(iutc_pkg::DAYS_PER_ERA);
    end

    // Stage 5: days since the epoch
    assign days_full = (iutc_pkg::DAYS_W+2)'(era_reg) + (iutc_pkg::DAYS_W+2)'(part_reg)
                       - (iutc_pkg::DAYS_W+2)'(cent_reg)
                       - (iutc_pkg::DAYS_W+2)'(iutc_pkg::EPOCH_SHIFT);
    always_ff @(posedge aclk) begin
        days_reg <= days_full[iutc_pkg::DAYS_W-1:0];
    end

    // Stage 6: seconds since the epoch
    always_ff @(posedge aclk) begin
        secs_reg <= iutc_pkg::SECS_W'(days_reg) * iutc_pkg::SECS_W'(iutc_pkg::SEC_PER_DAY)
                    + iutc_pkg::SECS_W'(tod_reg);
    end

    // Milliseconds, forced to zero for an invalid text
    assign ms_c = iutc_pkg::EPOCH_W'(secs_reg) * iutc_pkg::EPOCH_W'(iutc_pkg::MS_PER_SEC)
                  + iutc_pkg::EPOCH_W'(frac_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            valid_out_reg <= ok_reg;
            epoch_out_reg <= ok_reg ? ms_c : '0;
        end
    end

    assign valid_res = valid_out_reg;
    assign epoch_ms  = epoch_out_reg;

endmodule

// ===== src/iso_utc_timestamp_to_epoch_ms_unit.sv =====
// ----------------------------------------------------------------------------
// iso_utc_timestamp_to_epoch_ms_unit: ISO-8601 UTC timestamp to epoch time
// Parses a YYYY-MM-DDTHH:MM:SS[.fff]Z text one character per transaction and
// returns the Unix epoch time in milliseconds with a valid flag.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel carries one ASCII character per transaction in s_tdata;
// s_tlast marks the final character of a text. Each text produces exactly one
// transaction on the master channel: m_tuser is 1 for a well-formed, in-range
// timestamp and m_tdata holds the milliseconds since 1970-01-01T00:00:00Z,
// or zero when m_tuser is 0.
// Throughput: one character per cycle within a text. After the final
// character is accepted, s_tready stays low while the six-step
// days-from-civil and seconds arithmetic runs and the result is loaded;
// the next text's characters are not taken before that.
// m_tvalid rises when the result is loaded into the output register,
// after the field snapshot and the arithmetic steps.
// A stalled receiver holds the result in the output register; the parser
// keeps accepting the next text's characters, including its final one, but
// after that s_tready stays low until the previous result has been taken.
// Reset clears the parser and the output valid flag; the block is ready for
// a new text in the first cycle after reset.
// ----------------------------------------------------------------------------
module iso_utc_timestamp_to_epoch_ms_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [47:0] epoch_ms
    output logic        m_tuser    // [0] valid_res
);

    iutc_pkg::iutc_cmd_t cmd;

    iutc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    iutc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_char    (s_tdata),
        .valid_res (m_tuser),
        .epoch_ms  (m_tdata)
    );

    // The final character starts the calculation and closes the input.
    a_last_closes_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input still open after the final character");

    // An invalid text always reports a zero time.
    a_invalid_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("nonzero time on an invalid result");

    // A new result only appears after the input was closed for the calculation.
    a_result_after_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result loaded while the input was open");

endmodule
